// File: sv/surflet_gradient_noise_2d_unit_defines.svh
// Assertion helpers shared by the noise unit
`ifndef SURFLET_GRADIENT_NOISE_2D_UNIT_DEFINES_SVH
`define SURFLET_GRADIENT_NOISE_2D_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SGN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define SGN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sgn_pkg.sv
`default_nettype none
package sgn_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 8;
  localparam int ONE        = 1 << FRAC_W;
  localparam int NOISE_W    = 18;
  localparam int GRAD_W     = 16;
  localparam int FALL_W     = 15;
  localparam int TX_W       = FRAC_W + 2;
  localparam int DOT_W      = GRAD_W + TX_W + 1;
  localparam int W_W        = 2 * FALL_W;
  localparam int PROD_W     = W_W + 1 + DOT_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int RND_SH     = 28 + FRAC_W;
  localparam int Q_W        = SUM_W - RND_SH;
  localparam int NOISE_MAX  = 131071;
  localparam int NOISE_MIN  = -131072;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef logic [FALL_W-1:0]        fall_t;
  typedef logic signed [TX_W-1:0]   tx_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic [W_W-1:0]           weight_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef grad_t grad_tbl_t [TABLE_SIZE];
  typedef fall_t fall_tbl_t [TABLE_SIZE];

  // Hashed corners and falloffs, corner index is dy*2+dx
  typedef struct packed {
    logic                        valid;
    logic [3:0][IDX_W-1:0]       h;
    logic [1:0][FALL_W-1:0]      fall_x;
    logic [1:0][FALL_W-1:0]      fall_y;
    logic [FRAC_W-1:0]           fx;
    logic [FRAC_W-1:0]           fy;
  } hash_t;

  // Weighted corner contributions
  typedef struct packed {
    logic                        valid;
    logic [3:0][PROD_W-1:0]      prod;
  } corner_t;

  // Restoring long division, used only while building the constant tables
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Taylor series cos or sin of 2*3.1416*i/TABLE_SIZE, Q1.14
  function automatic grad_t grad_val(int i, bit sine);
    longint unsigned num;
    longint unsigned den;
    longint unsigned term;
    longint c;
    longint s;
    longint r;
    num  = 64'(62832) * 64'(i);
    den  = 64'(10000) * 64'(TABLE_SIZE);
    term = 64'd1 << 24;
    c    = 0;
    s    = 0;
    for (int n = 0; n < 80; n++) begin
      if (term != 0) begin
        if (n > 0) term = udiv(term * num, 64'(n) * den);
        case (n[1:0])
          2'd0:    c = c + longint'(term);
          2'd1:    s = s + longint'(term);
          2'd2:    c = c - longint'(term);
          default: s = s - longint'(term);
        endcase
      end
    end
    r = sine ? s : c;
    r = (r + 512) >>> 10;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return GRAD_W'(r);
  endfunction

  function automatic grad_tbl_t build_grad(bit sine);
    grad_tbl_t t;
    for (int i = 0; i < TABLE_SIZE; i++) t[i] = grad_val(i, sine);
    return t;
  endfunction

  // Falloff 1-(3-2a)a^2 rounded half up to Q1.14, a in Q.FRAC_W
  function automatic fall_t fall_val(int a);
    longint unsigned aa;
    longint unsigned num;
    aa = 64'(a);
    if (a >= ONE) return '0;
    num = (64'd1 << (3 * FRAC_W)) - aa * aa * (64'(3 * ONE) - 2 * aa);
    return FALL_W'(((num << 14) + (64'd1 << (3 * FRAC_W - 1))) >> (3 * FRAC_W));
  endfunction

  function automatic fall_tbl_t build_fall();
    fall_tbl_t t;
    for (int i = 0; i < TABLE_SIZE; i++) t[i] = fall_val(i);
    return t;
  endfunction

  localparam grad_tbl_t GRAD_COS = build_grad(1'b0);
  localparam grad_tbl_t GRAD_SIN = build_grad(1'b1);
  localparam fall_tbl_t FALL_TBL = build_fall();

endpackage
`default_nettype wire

// File: sv/sgn_ifs.sv
`default_nettype none
// Request channel: load or evaluate beats
interface sgn_req_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [sgn_pkg::COORD_W-1:0]   x_coord;
  logic [sgn_pkg::COORD_W-1:0]   y_coord;
  logic [sgn_pkg::IDX_W-1:0]     perm_index;
  logic [sgn_pkg::IDX_W-1:0]     perm_value;
  modport source (output valid, func, x_coord, y_coord, perm_index, perm_value,
                  input ready);
  modport sink   (input valid, func, x_coord, y_coord, perm_index, perm_value,
                  output ready);
endinterface

// Response channel: noise beats
interface sgn_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [sgn_pkg::NOISE_W-1:0] noise_value;
  logic                               saturated;
  modport source (output valid, noise_value, saturated, input ready);
  modport sink   (input valid, noise_value, saturated, output ready);
endinterface
`default_nettype wire

// File: sv/sgn_hash.sv
`default_nettype none
module sgn_hash (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    en,
  input  wire logic    acc,
  input  wire logic    func,
  input  wire logic [sgn_pkg::COORD_W-1:0] x_coord,
  input  wire logic [sgn_pkg::COORD_W-1:0] y_coord,
  input  wire logic [sgn_pkg::IDX_W-1:0]   perm_index,
  input  wire logic [sgn_pkg::IDX_W-1:0]   perm_value,
  output sgn_pkg::hash_t hash
);
  import sgn_pkg::*;

  // Three copies of the permutation table, one pair of read ports each
  logic [IDX_W-1:0] mem_a [TABLE_SIZE];
  logic [IDX_W-1:0] mem_b [TABLE_SIZE];
  logic [IDX_W-1:0] mem_c [TABLE_SIZE];

  logic             wr;
  logic [IDX_W-1:0] cx;
  logic [IDX_W-1:0] cx1;
  logic             v0;
  logic [IDX_W-1:0] p0;
  logic [IDX_W-1:0] p1;
  logic [IDX_W-1:0] cy0;
  logic [FRAC_W-1:0] fx0;
  logic [FRAC_W-1:0] fy0;
  logic [IDX_W-1:0] a00, a10, a01, a11;
  logic [FRAC_W-1:0] nfx, nfy;

  assign wr  = acc && (func == FUNC_LOAD);
  assign cx  = x_coord[FRAC_W +: IDX_W];
  assign cx1 = cx + IDX_W'(1);

  // Write loads at acceptance; first hash level reads with the beat
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_a[perm_index] <= perm_value;
      mem_b[perm_index] <= perm_value;
      mem_c[perm_index] <= perm_value;
    end
    if (en) begin
      p0  <= mem_a[cx];
      p1  <= mem_a[cx1];
      cy0 <= y_coord[FRAC_W +: IDX_W];
      fx0 <= x_coord[FRAC_W-1:0];
      fy0 <= y_coord[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= acc && (func == FUNC_EVAL);
    end
  end

  assign a00 = p0 + cy0;
  assign a10 = p1 + cy0;
  assign a01 = p0 + cy0 + IDX_W'(1);
  assign a11 = p1 + cy0 + IDX_W'(1);
  assign nfx = FRAC_W'(0) - fx0;
  assign nfy = FRAC_W'(0) - fy0;

  // Second hash level and falloffs; far corner drops out on zero fraction
  always_ff @(posedge clk) begin
    if (en) begin
      hash.h[0]      <= mem_b[a00];
      hash.h[1]      <= mem_b[a10];
      hash.h[2]      <= mem_c[a01];
      hash.h[3]      <= mem_c[a11];
      hash.fall_x[0] <= FALL_TBL[fx0];
      hash.fall_x[1] <= (fx0 == '0) ? '0 : FALL_TBL[nfx];
      hash.fall_y[0] <= FALL_TBL[fy0];
      hash.fall_y[1] <= (fy0 == '0) ? '0 : FALL_TBL[nfy];
      hash.fx        <= fx0;
      hash.fy        <= fy0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash.valid <= 1'b0;
    end else if (en) begin
      hash.valid <= v0;
    end
  end
endmodule
`default_nettype wire

// File: sv/sgn_corner.sv
`default_nettype none
module sgn_corner (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  sgn_pkg::hash_t hash,
  output sgn_pkg::corner_t corner
);
  import sgn_pkg::*;

  grad_t   gc [4];
  grad_t   gs [4];
  tx_t     tx [4];
  tx_t     ty [4];
  weight_t w2 [4];
  weight_t w3 [4];
  dot_t    dot [4];
  logic    v2, v3;

  // Gradient lookup, offsets and falloff product per corner
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        gc[i] <= GRAD_COS[hash.h[i]];
        gs[i] <= GRAD_SIN[hash.h[i]];
        tx[i] <= i[0] ? tx_t'({2'b00, hash.fx}) - tx_t'(ONE)
                      : tx_t'({2'b00, hash.fx});
        ty[i] <= i[1] ? tx_t'({2'b00, hash.fy}) - tx_t'(ONE)
                      : tx_t'({2'b00, hash.fy});
        w2[i] <= weight_t'(hash.fall_x[i[0]]) * weight_t'(hash.fall_y[i[1]]);
      end
    end
  end

  // Dot of gradient and offset
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dot[i] <= DOT_W'(gc[i]) * DOT_W'(tx[i]) + DOT_W'(gs[i]) * DOT_W'(ty[i]);
        w3[i]  <= w2[i];
      end
    end
  end

  // Scale the dot by the falloff weight
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        corner.prod[i] <= PROD_W'($signed({1'b0, w3[i]})) * PROD_W'(dot[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2           <= 1'b0;
      v3           <= 1'b0;
      corner.valid <= 1'b0;
    end else if (en) begin
      v2           <= hash.valid;
      v3           <= v2;
      corner.valid <= v3;
    end
  end
endmodule
`default_nettype wire

// File: sv/surflet_gradient_noise_2d_unit.sv
// Throughput: one beat per cycle, loads and evaluates alike; the seven-stage
// pipeline holds as a whole only while a finished result waits at the output.
// Loads write the permutation table in the cycle they are accepted.
// Reset (rst, synchronous) clears all valid bits; the table is undefined until loaded.
`default_nettype none
`include "surflet_gradient_noise_2d_unit_defines.svh"
module surflet_gradient_noise_2d_unit (
  input wire logic clk,
  input wire logic rst,
  sgn_req_if.sink  req,
  sgn_rsp_if.source rsp
);
  import sgn_pkg::*;

  logic                     en;
  logic                     acc;
  hash_t                    hash;
  corner_t                  corner;
  logic signed [PAIR_W-1:0] pa, pb;
  logic                     v5;
  logic signed [SUM_W-1:0]  total;
  logic signed [Q_W-1:0]    q;

  // Advance unless the output beat is held
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign acc       = req.valid && en;

  sgn_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .acc        (acc),
    .func       (req.func),
    .x_coord    (req.x_coord),
    .y_coord    (req.y_coord),
    .perm_index (req.perm_index),
    .perm_value (req.perm_value),
    .hash       (hash)
  );

  sgn_corner u_corner (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .hash   (hash),
    .corner (corner)
  );

  // Sum corner pairs
  always_ff @(posedge clk) begin
    if (en) begin
      pa <= PAIR_W'($signed(corner.prod[0])) + PAIR_W'($signed(corner.prod[1]));
      pb <= PAIR_W'($signed(corner.prod[2])) + PAIR_W'($signed(corner.prod[3]));
    end
  end

  // Round half up to Q3.14 and clip
  assign total = SUM_W'(pa) + SUM_W'(pb) + (SUM_W'(1) <<< (RND_SH - 1));
  assign q     = Q_W'(total >>> RND_SH);

  always_ff @(posedge clk) begin
    if (en) begin
      if (q > Q_W'(NOISE_MAX)) begin
        rsp.noise_value <= NOISE_W'(NOISE_MAX);
        rsp.saturated   <= 1'b1;
      end else if (q < Q_W'(NOISE_MIN)) begin
        rsp.noise_value <= NOISE_W'(NOISE_MIN);
        rsp.saturated   <= 1'b1;
      end else begin
        rsp.noise_value <= NOISE_W'(q);
        rsp.saturated   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      v5        <= corner.valid;
      rsp.valid <= v5;
    end
  end

  `SGN_ASSERT_NOW(a_ready_follows_output, 1'b1, req.ready == (!rsp.valid || rsp.ready), "ready mismatch")
  `SGN_ASSERT_NOW(a_sat_at_limit, rsp.valid && rsp.saturated, (rsp.noise_value == NOISE_W'(NOISE_MAX)) || (rsp.noise_value == NOISE_W'(NOISE_MIN)), "saturated flag without clipped value")
  `SGN_ASSERT_NEXT(a_hold_output, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.noise_value) && $stable(rsp.saturated), "held output beat changed")

endmodule
`default_nettype wire
